// ===== design/srsl_pkg.sv =====
`timescale 1ns / 1ps

package srsl_pkg;

    // width of every configuration register
    localparam int REG_WIDTH = 19;
    localparam int CFG_INDEX_WIDTH = 2;

    // preset reset values in whole rpm, scaled by the fraction bits at elaboration
    localparam int SLOW_PRESET_RPM = 40;
    localparam int FAST_PRESET_RPM = 400;
    localparam int STEP_RPM = 1;

    // action codes
    localparam logic ACTION_COMMAND = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // speed choice codes
    localparam logic [1:0] CHOICE_STOP = 2'd0;
    localparam logic [1:0] CHOICE_CHORALE = 2'd1;
    localparam logic [1:0] CHOICE_TREMOLO = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHORALE_TARGET = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TREMOLO_TARGET = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RISE_STEP = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FALL_STEP = 2'd3;

    typedef logic [REG_WIDTH-1:0] reg_word_t;

    typedef struct packed {
        reg_word_t chorale_target;
        reg_word_t tremolo_target;
        reg_word_t rise_step;
        reg_word_t fall_step;
    } cfg_t;

    // control part of one held input item
    typedef struct packed {
        logic       action;
        logic [1:0] speed_choice;
        logic [1:0] reference_source;
        logic       measured_valid;
    } item_ctl_t;

endpackage

// ===== design/srsl_cfg_if.sv =====
`timescale 1ns / 1ps

interface srsl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [srsl_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [srsl_pkg::REG_WIDTH-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/srsl_item_if.sv =====
`timescale 1ns / 1ps

interface srsl_item_if #(
    parameter int SPEED_WIDTH = 20
);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [1:0]                    speed_choice;
    logic [1:0]                    reference_source;
    logic                          measured_valid;
    logic signed [SPEED_WIDTH-1:0] measured_speed;

    modport source (
        output valid, output action, output speed_choice, output reference_source,
        output measured_valid, output measured_speed, input ready
    );
    modport sink (
        input valid, input action, input speed_choice, input reference_source,
        input measured_valid, input measured_speed, output ready
    );
endinterface

// ===== design/srsl_result_if.sv =====
`timescale 1ns / 1ps

interface srsl_result_if #(
    parameter int SPEED_WIDTH = 20
);
    logic                          valid;
    logic                          ready;
    logic signed [SPEED_WIDTH-1:0] reference_speed;
    logic [1:0]                    reference_tag;
    logic                          settled;

    modport source (
        output valid, output reference_speed, output reference_tag, output settled,
        input ready
    );
    modport sink (
        input valid, input reference_speed, input reference_tag, input settled,
        output ready
    );
endinterface

// ===== design/speed_ramp_slew_limiter.sv =====
`timescale 1ns / 1ps

// Speed setpoint ramp generator. A command transfer (action 0) picks a target
// (stop, chorale preset or tremolo preset; the unused choice code also means
// stop), starts the ramp
// at measured_speed when measured_valid is set, otherwise at the last ramped
// speed, and always returns one result carrying that start speed. Each tick
// transfer (action 1) moves the setpoint toward the target by at most rise_step
// going up or fall_step going down, and returns one result; a tick while no ramp
// runs returns nothing. A zero step jumps straight to the target. settled is set
// on the result that reaches the target, which ends the ramp. Speeds are signed
// with FRACTION_BITS fraction bits; presets above the signed speed range are
// saturated. The block takes one item every cycle while results are taken: an
// input register and a result register sit either side of a single add,
// compare and clamp stage. While a result waits the input register holds one
// more item, then the input stalls until the result is taken. Write
// configuration only while idle.
module speed_ramp_slew_limiter #(
    parameter int SPEED_WIDTH = 20,
    parameter int FRACTION_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    srsl_cfg_if.sink      cfg,
    srsl_item_if.sink     item,
    srsl_result_if.source result
);
    import srsl_pkg::*;

    // configuration registers, reset to presets scaled by the fraction bits
    cfg_t                          regs;

    // held item between input register and ramp stage
    logic                          hold_valid;
    item_ctl_t                     hold_ctl;
    logic signed [SPEED_WIDTH-1:0] hold_speed;

    // high when the ramp stage consumes the held item this cycle
    logic                          take;

    srsl_cfg_regs #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // input register: frees itself as the held item moves on
    srsl_in_stage #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_ctl   (hold_ctl),
        .hold_speed (hold_speed)
    );

    // ramp state, step logic and result register
    srsl_ramp_core #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_ramp_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs),
        .hold_valid (hold_valid),
        .hold_ctl   (hold_ctl),
        .hold_speed (hold_speed),
        .take       (take),
        .result     (result)
    );

endmodule

// ===== design/srsl_cfg_regs.sv =====
`timescale 1ns / 1ps

module srsl_cfg_regs #(
    parameter int FRACTION_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    srsl_cfg_if.sink       cfg,
    output srsl_pkg::cfg_t regs
);
    import srsl_pkg::*;

    localparam reg_word_t CHORALE_RESET =
        REG_WIDTH'(longint'(SLOW_PRESET_RPM) << FRACTION_BITS);
    localparam reg_word_t TREMOLO_RESET =
        REG_WIDTH'(longint'(FAST_PRESET_RPM) << FRACTION_BITS);
    localparam reg_word_t STEP_RESET = REG_WIDTH'(longint'(STEP_RPM) << FRACTION_BITS);

    cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.chorale_target <= CHORALE_RESET;
            regs_reg.tremolo_target <= TREMOLO_RESET;
            regs_reg.rise_step <= STEP_RESET;
            regs_reg.fall_step <= STEP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CHORALE_TARGET: regs_reg.chorale_target <= cfg.data;
                CFG_TREMOLO_TARGET: regs_reg.tremolo_target <= cfg.data;
                CFG_RISE_STEP:      regs_reg.rise_step <= cfg.data;
                CFG_FALL_STEP:      regs_reg.fall_step <= cfg.data;
                default:            ;
            endcase
        end
    end

endmodule

// ===== design/srsl_in_stage.sv =====
`timescale 1ns / 1ps

module srsl_in_stage #(
    parameter int SPEED_WIDTH = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    srsl_item_if.sink                     item,
    input  logic                          take,
    output logic                          hold_valid,
    output srsl_pkg::item_ctl_t           hold_ctl,
    output logic signed [SPEED_WIDTH-1:0] hold_speed
);
    import srsl_pkg::*;

    logic                          hold_valid_reg;
    item_ctl_t                     ctl_reg;
    logic signed [SPEED_WIDTH-1:0] speed_reg;
    logic                          accept;

    // free when empty or when the held item leaves this cycle
    assign item.ready = !hold_valid_reg || take;
    assign accept = item.valid && item.ready;

    assign hold_valid = hold_valid_reg;
    assign hold_ctl = ctl_reg;
    assign hold_speed = speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg.action <= item.action;
            ctl_reg.speed_choice <= item.speed_choice;
            ctl_reg.reference_source <= item.reference_source;
            ctl_reg.measured_valid <= item.measured_valid;
            speed_reg <= item.measured_speed;
        end
    end

endmodule

// ===== design/srsl_ramp_core.sv =====
`timescale 1ns / 1ps

module srsl_ramp_core #(
    parameter int SPEED_WIDTH = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  srsl_pkg::cfg_t                regs,
    input  logic                          hold_valid,
    input  srsl_pkg::item_ctl_t           hold_ctl,
    input  logic signed [SPEED_WIDTH-1:0] hold_speed,
    output logic                          take,
    srsl_result_if.source                 result
);
    import srsl_pkg::*;

    // working width: holds a speed difference and any step without overflow
    localparam int DW = ((SPEED_WIDTH > REG_WIDTH) ? SPEED_WIDTH : REG_WIDTH) + 2;
    localparam logic signed [DW-1:0] SPD_MAX =
        DW'((longint'(1) << (SPEED_WIDTH - 1)) - longint'(1));

    logic signed [SPEED_WIDTH-1:0] cur_reg, cur_next;
    logic signed [SPEED_WIDTH-1:0] goal_reg, goal_next;
    logic signed [SPEED_WIDTH-1:0] last_reg, last_next;
    logic                          active_reg, active_next;
    logic [1:0]                    tag_reg, tag_next;

    logic                          res_v_reg, res_v_next;
    logic signed [SPEED_WIDTH-1:0] res_speed_reg, res_speed_next;
    logic [1:0]                    res_tag_reg, res_tag_next;
    logic                          res_settled_reg, res_settled_next;

    logic                          fire;
    logic signed [DW-1:0]          chorale_w, tremolo_w, target_w;
    logic signed [SPEED_WIDTH-1:0] target;
    logic signed [SPEED_WIDTH-1:0] start;
    logic signed [DW-1:0]          delta, step, move;
    logic signed [SPEED_WIDTH-1:0] stepped;

    assign fire = hold_valid && (!res_v_reg || result.ready);
    assign take = fire;

    // preset targets, saturated into the signed speed range
    always_comb
    begin
        chorale_w = signed'({{(DW - REG_WIDTH){1'b0}}, regs.chorale_target});
        tremolo_w = signed'({{(DW - REG_WIDTH){1'b0}}, regs.tremolo_target});
        if (chorale_w > SPD_MAX)
        begin
            chorale_w = SPD_MAX;
        end
        if (tremolo_w > SPD_MAX)
        begin
            tremolo_w = SPD_MAX;
        end
        case (hold_ctl.speed_choice)
            CHOICE_CHORALE: target_w = chorale_w;
            CHOICE_TREMOLO: target_w = tremolo_w;
            default:        target_w = '0;
        endcase
        target = SPEED_WIDTH'(target_w);
        start = hold_ctl.measured_valid ? hold_speed : last_reg;
    end

    // one clamped step toward the goal
    always_comb
    begin
        delta = DW'(goal_reg) - DW'(cur_reg);
        step = signed'({{(DW - REG_WIDTH){1'b0}},
                        (delta > 0) ? regs.rise_step : regs.fall_step});
        if (delta > step)
        begin
            move = step;
        end
        else if (delta < -step)
        begin
            move = -step;
        end
        else
        begin
            move = delta;
        end
        if (step == '0)
        begin
            stepped = goal_reg;
        end
        else
        begin
            stepped = SPEED_WIDTH'(DW'(cur_reg) + move);
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        goal_next = goal_reg;
        last_next = last_reg;
        active_next = active_reg;
        tag_next = tag_reg;
        res_v_next = res_v_reg && !result.ready;
        res_speed_next = res_speed_reg;
        res_tag_next = res_tag_reg;
        res_settled_next = res_settled_reg;
        if (fire)
        begin
            res_v_next = 1'b0;
            if (hold_ctl.action == ACTION_COMMAND)
            begin
                cur_next = start;
                goal_next = target;
                tag_next = hold_ctl.reference_source;
                active_next = (start != target);
                if (start == target)
                begin
                    last_next = start;
                end
                res_v_next = 1'b1;
                res_speed_next = start;
                res_tag_next = hold_ctl.reference_source;
                res_settled_next = (start == target);
            end
            else if (active_reg)
            begin
                cur_next = stepped;
                last_next = stepped;
                active_next = (stepped != goal_reg);
                res_v_next = 1'b1;
                res_speed_next = stepped;
                res_tag_next = tag_reg;
                res_settled_next = (stepped == goal_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            goal_reg <= '0;
            last_reg <= '0;
            active_reg <= 1'b0;
            tag_reg <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
            goal_reg <= goal_next;
            last_reg <= last_next;
            active_reg <= active_next;
            tag_reg <= tag_next;
            res_v_reg <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_speed_reg <= res_speed_next;
        res_tag_reg <= res_tag_next;
        res_settled_reg <= res_settled_next;
    end

    assign result.valid = res_v_reg;
    assign result.reference_speed = res_speed_reg;
    assign result.reference_tag = res_tag_reg;
    assign result.settled = res_settled_reg;

    // a ramp in progress never sits on its goal
    a_active_off_goal: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> cur_reg != goal_reg)
        else $error("ramp active with setpoint at goal");

    // a settled result leaves the ramp idle, an unsettled one leaves it running
    a_settled_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg && res_settled_reg |-> !active_reg)
        else $error("settled result while ramp active");

    a_unsettled_active: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg && !res_settled_reg |-> active_reg)
        else $error("unsettled result while ramp idle");

    // a waiting result always shows the present setpoint
    a_result_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        res_v_reg |-> res_speed_reg == cur_reg)
        else $error("result speed differs from setpoint");

    // a tick while idle gives nothing and changes nothing
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        fire && hold_ctl.action == ACTION_TICK && !active_reg
        |=> !res_v_reg && $stable(cur_reg) && $stable(last_reg))
        else $error("idle tick disturbed the ramp");

endmodule

// ===== bench/speed_ramp_slew_limiter_test.sv =====
`timescale 1ns / 1ps

module speed_ramp_slew_limiter_test;

    import srsl_pkg::*;

    localparam int SPEED_WIDTH = 20;
    localparam int FRACTION_BITS = 8;
    localparam int SPEED_MAX = 2 ** (SPEED_WIDTH - 1) - 1;
    localparam int SPEED_MIN = -(2 ** (SPEED_WIDTH - 1));
    localparam int REG_MAX = 2 ** REG_WIDTH - 1;

    // the one choice code with no name in the package, treated as stop
    localparam logic [1:0] CHOICE_UNUSED = 2'd3;

    // random part: six settings, each run until this many transfers have been offered
    localparam int PHASE_COUNT = 6;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PRESSURE_PHASE = 4;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef logic signed [SPEED_WIDTH-1:0] speed_t;
    // room for goal minus speed plus a full step without wrapping
    typedef logic signed [SPEED_WIDTH+1:0] wide_t;

    typedef struct packed {
        logic       action;
        logic [1:0] choice;
        logic [1:0] source;
        logic       mvalid;
        speed_t     mspeed;
    } ramp_item_t;

    typedef struct packed {
        speed_t     speed;
        logic [1:0] tag;
        logic       settled;
    } ramp_result_t;

    // how a row of the directed table gets its expectation
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_RESULT,
        ROW_SILENT
    } row_kind_e;

    typedef struct {
        row_kind_e    kind;
        ramp_item_t   stim;
        ramp_result_t want;
    } row_t;

    logic clk;
    logic rst_n;

    srsl_cfg_if cfg_bus ();
    srsl_item_if #(.SPEED_WIDTH(SPEED_WIDTH)) item_bus ();
    srsl_result_if #(.SPEED_WIDTH(SPEED_WIDTH)) result_bus ();

    speed_ramp_slew_limiter #(
        .SPEED_WIDTH(SPEED_WIDTH),
        .FRACTION_BITS(FRACTION_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_bus),
        .item(item_bus),
        .result(result_bus)
    );

    // shadow of the ramp generator: configuration and ramp state
    cfg_t   ramp_cfg;
    speed_t ramp_speed;
    speed_t ramp_goal;
    logic   ramp_running;
    logic [1:0] ramp_tag;
    speed_t held_speed;

    ramp_result_t pending_setpoints[$];
    row_t         directed_rows[$];

    int  burst_left;
    bit  pressure_req;
    int  mismatch_count;
    int  setpoints_checked;
    int  command_count;
    int  tick_count;
    int  idle_tick_count;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // preset register as a signed target, clipped to the speed range
    function automatic speed_t preset_speed(input reg_word_t r);
        if (int'(r) > SPEED_MAX)
            return speed_t'(SPEED_MAX);
        return speed_t'(r);
    endfunction

    function automatic speed_t choice_goal(input logic [1:0] choice);
        case (choice)
            CHOICE_CHORALE: return preset_speed(ramp_cfg.chorale_target);
            CHOICE_TREMOLO: return preset_speed(ramp_cfg.tremolo_target);
            default:        return '0;
        endcase
    endfunction

    // moves the shadow ramp by one transfer; returns 1 when a setpoint follows
    function automatic bit advance_ramp(input ramp_item_t stim, output ramp_result_t res);
        wide_t diff;
        wide_t lim;
        res = '0;
        if (stim.action == ACTION_COMMAND)
        begin
            ramp_speed = stim.mvalid ? stim.mspeed : held_speed;
            ramp_goal = choice_goal(stim.choice);
            ramp_tag = stim.source;
            ramp_running = (ramp_speed != ramp_goal);
            // a start that is already on target counts as a ramped speed
            if (!ramp_running)
                held_speed = ramp_speed;
        end
        else
        begin
            if (!ramp_running)
                return 1'b0;
            diff = wide_t'(ramp_goal) - wide_t'(ramp_speed);
            lim = (diff > 0) ? wide_t'(ramp_cfg.rise_step) : wide_t'(ramp_cfg.fall_step);
            if (lim == 0)
                ramp_speed = ramp_goal;
            else
            begin
                if (diff > lim)
                    diff = lim;
                if (diff < -lim)
                    diff = -lim;
                ramp_speed = speed_t'(wide_t'(ramp_speed) + diff);
            end
            held_speed = ramp_speed;
            ramp_running = (ramp_speed != ramp_goal);
        end
        res.speed = ramp_speed;
        res.tag = ramp_tag;
        res.settled = !ramp_running;
        return 1'b1;
    endfunction

    function automatic ramp_item_t command_item(input logic [1:0] choice,
                                                input logic [1:0] source,
                                                input logic mvalid,
                                                input speed_t mspeed);
        ramp_item_t it;
        it.action = ACTION_COMMAND;
        it.choice = choice;
        it.source = source;
        it.mvalid = mvalid;
        it.mspeed = mspeed;
        return it;
    endfunction

    // ticks carry random junk in the fields the block should ignore
    function automatic ramp_item_t tick_item();
        ramp_item_t it;
        it = ramp_item_t'({$urandom, $urandom});
        it.action = ACTION_TICK;
        return it;
    endfunction

    function automatic ramp_result_t setpoint(input speed_t speed, input logic [1:0] tag,
                                              input logic settled);
        ramp_result_t r;
        r.speed = speed;
        r.tag = tag;
        r.settled = settled;
        return r;
    endfunction

    task automatic add_row(input row_kind_e kind, input ramp_item_t stim,
                           input ramp_result_t want);
        row_t row;
        row.kind = kind;
        row.stim = stim;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // mostly a start near the chosen target so ramps settle within a short run of ticks
    function automatic ramp_item_t random_command();
        ramp_item_t it;
        speed_t     goal;
        int         span;
        longint     v;
        it = command_item(2'($urandom_range(0, 3)), 2'($urandom), 1'b0, speed_t'($urandom));
        it.mvalid = ($urandom_range(0, 3) != 0);
        goal = choice_goal(it.choice);
        span = (ramp_cfg.rise_step > ramp_cfg.fall_step) ? int'(ramp_cfg.rise_step)
                                                          : int'(ramp_cfg.fall_step);
        if (span == 0)
            span = 256;
        if (span > 65536)
            span = 65536;
        span = span * 6;
        case ($urandom_range(0, 7))
            0:       it.mspeed = goal;
            1, 2:    ;
            default:
            begin
                v = longint'(goal) + longint'($urandom_range(0, 2 * span)) - span;
                if (v > SPEED_MAX)
                    v = SPEED_MAX;
                if (v < SPEED_MIN)
                    v = SPEED_MIN;
                it.mspeed = speed_t'(v);
            end
        endcase
        return it;
    endfunction

    // offers one transfer in the current burst, then books its expectation
    task automatic offer(input ramp_item_t stim, input row_kind_e kind,
                         input ramp_result_t want, output bit gives);
        ramp_result_t res;
        if (burst_left == 0)
        begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 10);
        end
        item_bus.valid <= 1'b1;
        item_bus.action <= stim.action;
        item_bus.speed_choice <= stim.choice;
        item_bus.reference_source <= stim.source;
        item_bus.measured_valid <= stim.mvalid;
        item_bus.measured_speed <= stim.mspeed;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        burst_left--;
        gives = advance_ramp(stim, res);
        if (stim.action == ACTION_COMMAND)
            command_count++;
        else
        begin
            tick_count++;
            if (!gives)
                idle_tick_count++;
        end
        case (kind)
            ROW_PREDICT:
                if (gives)
                    pending_setpoints.push_back(res);
            ROW_RESULT:
                pending_setpoints.push_back(want);
            default:
                ;
        endcase
    endtask

    task automatic end_burst();
        item_bus.valid <= 1'b0;
        burst_left = 0;
    endtask

    // idle means every setpoint is in and a stray tick has left the pipeline
    task automatic settle();
        while (pending_setpoints.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // all four registers back to back, valid held high across the writes
    task automatic load_config(input cfg_t c);
        logic [CFG_INDEX_WIDTH-1:0] idx[4];
        reg_word_t                  vals[4];
        idx[0] = CFG_CHORALE_TARGET;
        idx[1] = CFG_TREMOLO_TARGET;
        idx[2] = CFG_RISE_STEP;
        idx[3] = CFG_FALL_STEP;
        vals[0] = c.chorale_target;
        vals[1] = c.tremolo_target;
        vals[2] = c.rise_step;
        vals[3] = c.fall_step;
        for (int k = 0; k < 4; k++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[k];
            cfg_bus.data <= vals[k];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
        end
        cfg_bus.valid <= 1'b0;
        ramp_cfg = c;
    endtask

    // commands followed by runs of ticks, with some short tick runs and lone commands as noise
    task automatic run_phase(input int quota);
        int got;
        int ticks;
        bit gives;
        got = 0;
        while (got < quota)
        begin
            case ($urandom_range(0, 19))
                17, 18:
                    repeat ($urandom_range(1, 4))
                    begin
                        offer(tick_item(), ROW_PREDICT, '0, gives);
                        got++;
                    end
                19:
                begin
                    offer(random_command(), ROW_PREDICT, '0, gives);
                    got++;
                end
                default:
                begin
                    offer(random_command(), ROW_PREDICT, '0, gives);
                    got++;
                    ticks = $urandom_range(0, 14);
                    repeat (ticks)
                    begin
                        offer(tick_item(), ROW_PREDICT, '0, gives);
                        got++;
                    end
                end
            endcase
        end
        end_burst();
    endtask

    // setpoint sink: checks each transfer against the oldest expectation
    initial
    begin : setpoint_sink
        int           cyc;
        int           hold_left;
        bit           go;
        ramp_result_t want;
        cyc = 0;
        hold_left = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (pending_setpoints.size() == 0)
                begin
                    $error("setpoint transfer with nothing expected: speed %0d tag %0d",
                           result_bus.reference_speed, result_bus.reference_tag);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_setpoints.pop_front();
                    setpoints_checked++;
                    if (result_bus.reference_speed !== want.speed)
                    begin
                        $error("reference_speed: expected %0d, got %0d",
                               want.speed, result_bus.reference_speed);
                        mismatch_count++;
                    end
                    if (result_bus.reference_tag !== want.tag)
                    begin
                        $error("reference_tag: expected %0d, got %0d",
                               want.tag, result_bus.reference_tag);
                        mismatch_count++;
                    end
                    if (result_bus.settled !== want.settled)
                    begin
                        $error("settled: expected %0d, got %0d",
                               want.settled, result_bus.settled);
                        mismatch_count++;
                    end
                end
            end
            cyc++;
            // long hold-off so the block backs up into its input
            if (hold_left > 0)
                hold_left--;
            else if (pressure_req)
            begin
                pressure_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
                go = 1'b0;
            else
                case ((cyc / 50) % 4)
                    0:       go = 1'b1;
                    1:       go = $urandom_range(0, 1);
                    2:       go = (cyc % 3 == 0);
                    default: go = ($urandom_range(0, 3) != 0);
                endcase
            result_bus.ready <= go;
        end
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #2_000_000;
        $display("[speed_ramp_slew_limiter] ERROR");
        $finish;
    end

    initial
    begin
        cfg_t cfg_now;
        bit   gives;
        mismatch_count = 0;
        setpoints_checked = 0;
        command_count = 0;
        tick_count = 0;
        idle_tick_count = 0;
        burst_left = 0;
        pressure_req = 1'b0;

        // shadow state as after reset
        ramp_cfg.chorale_target = reg_word_t'(SLOW_PRESET_RPM << FRACTION_BITS);
        ramp_cfg.tremolo_target = reg_word_t'(FAST_PRESET_RPM << FRACTION_BITS);
        ramp_cfg.rise_step = reg_word_t'(STEP_RPM << FRACTION_BITS);
        ramp_cfg.fall_step = reg_word_t'(STEP_RPM << FRACTION_BITS);
        ramp_speed = '0;
        ramp_goal = '0;
        ramp_running = 1'b0;
        ramp_tag = '0;
        held_speed = '0;

        rst_n <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data <= '0;
        item_bus.valid <= 1'b0;
        item_bus.action <= ACTION_COMMAND;
        item_bus.speed_choice <= CHOICE_STOP;
        item_bus.reference_source <= '0;
        item_bus.measured_valid <= 1'b0;
        item_bus.measured_speed <= '0;

        // directed table, run with the reset presets: 40 and 400 rpm, 1 rpm steps
        add_row(ROW_SILENT, tick_item(), '0);
        add_row(ROW_RESULT, command_item(CHOICE_STOP, 2'd1, 1'b0, 0),
                setpoint(0, 2'd1, 1'b1));
        add_row(ROW_RESULT, command_item(CHOICE_CHORALE, 2'd2, 1'b1, 9984),
                setpoint(9984, 2'd2, 1'b0));
        add_row(ROW_RESULT, tick_item(), setpoint(10240, 2'd2, 1'b1));
        add_row(ROW_SILENT, tick_item(), '0);
        // most negative measured speed, then the most positive replacing the ramp
        add_row(ROW_RESULT, command_item(CHOICE_TREMOLO, 2'd3, 1'b1, SPEED_MIN),
                setpoint(SPEED_MIN, 2'd3, 1'b0));
        add_row(ROW_PREDICT, tick_item(), '0);
        add_row(ROW_RESULT, command_item(CHOICE_STOP, 2'd0, 1'b1, SPEED_MAX),
                setpoint(SPEED_MAX, 2'd0, 1'b0));
        add_row(ROW_PREDICT, tick_item(), '0);
        // unused choice behaves as stop, start taken from the last ramped speed
        add_row(ROW_PREDICT, command_item(CHOICE_UNUSED, 2'd1, 1'b0, SPEED_MIN), '0);
        add_row(ROW_PREDICT, tick_item(), '0);
        add_row(ROW_PREDICT, command_item(CHOICE_CHORALE, 2'd2, 1'b0, 0), '0);
        // start already on target: settled straight from the command
        add_row(ROW_RESULT, command_item(CHOICE_TREMOLO, 2'd2, 1'b1, 102400),
                setpoint(102400, 2'd2, 1'b1));
        add_row(ROW_SILENT, tick_item(), '0);
        // remaining distance below one step lands exactly on target
        add_row(ROW_RESULT, command_item(CHOICE_STOP, 2'd0, 1'b1, 1),
                setpoint(1, 2'd0, 1'b0));
        add_row(ROW_RESULT, tick_item(), setpoint(0, 2'd0, 1'b1));
        add_row(ROW_PREDICT, command_item(CHOICE_CHORALE, 2'd3, 1'b1, 20000), '0);
        add_row(ROW_PREDICT, tick_item(), '0);
        add_row(ROW_RESULT, command_item(CHOICE_STOP, 2'd1, 1'b1, -300),
                setpoint(-300, 2'd1, 1'b0));
        add_row(ROW_PREDICT, tick_item(), '0);
        add_row(ROW_RESULT, tick_item(), setpoint(0, 2'd1, 1'b1));
        add_row(ROW_SILENT, tick_item(), '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].stim, directed_rows[i].kind, directed_rows[i].want, gives);
        end_burst();

        // random part, one configuration setting per phase
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            cfg_now.chorale_target = reg_word_t'($urandom_range(0, 200000));
            cfg_now.tremolo_target = reg_word_t'($urandom_range(0, REG_MAX));
            cfg_now.rise_step = reg_word_t'($urandom_range(1, 2048));
            cfg_now.fall_step = reg_word_t'($urandom_range(1, 2048));
            case (p)
                0:
                begin
                    // both steps zero: every tick jumps to target
                    cfg_now.rise_step = '0;
                    cfg_now.fall_step = '0;
                end
                1:
                    cfg_now = '1;
                2:
                begin
                    cfg_now.chorale_target = '0;
                    cfg_now.tremolo_target = '0;
                    cfg_now.rise_step = reg_word_t'(1);
                    cfg_now.fall_step = reg_word_t'(1);
                end
                3:
                    cfg_now.rise_step = '0;
                5:
                begin
                    cfg_now.rise_step = reg_word_t'($urandom_range(0, REG_MAX));
                    cfg_now.fall_step = '0;
                end
                default:
                    ;
            endcase
            settle();
            load_config(cfg_now);
            if (p == PRESSURE_PHASE)
                pressure_req = 1'b1;
            run_phase(ITEMS_PER_PHASE);
        end

        while (pending_setpoints.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d commands and %0d ticks (%0d while idle) over %0d settings",
                 command_count, tick_count, idle_tick_count, PHASE_COUNT + 1);
        $display("checked %0d setpoints, %0d mismatches", setpoints_checked, mismatch_count);
        if (mismatch_count == 0 && pending_setpoints.size() == 0)
            $display("[speed_ramp_slew_limiter] OK");
        else
            $display("[speed_ramp_slew_limiter] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/srsl_pkg.sv
design/srsl_cfg_if.sv
design/srsl_item_if.sv
design/srsl_result_if.sv
design/srsl_cfg_regs.sv
design/srsl_in_stage.sv
design/srsl_ramp_core.sv
design/speed_ramp_slew_limiter.sv
bench/speed_ramp_slew_limiter_test.sv
